// ===== rtl/hmf_pkg.sv =====
// Shared widths, types and saturating add for the H^H y matched-filter block.
// No dependencies; every other file imports this package.
package hmf_pkg;

  localparam int NUM_STREAMS = 4;
  localparam int DEPTH       = 64;
  localparam int SC_W        = 6;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int TERM_W      = PROD_W + 1;
  localparam int ACC_W       = 40;
  localparam int ACC_PER_ROW = 2 * NUM_STREAMS;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // One memory row: element 2k is stream k real, 2k+1 is stream k imaginary
  typedef acc_t  [ACC_PER_ROW-1:0] acc_row_t;
  typedef term_t [ACC_PER_ROW-1:0] term_row_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Accumulator plus term, clamped to the 40-bit signed range
  function automatic acc_t sat_add(acc_t a, term_t t);
    logic signed [ACC_W:0] s;
    acc_t                  r;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(t);
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/hmf_in_if.sv =====
// Input channel: one receive antenna sample and its four channel entries.
// Depends on hmf_pkg.
interface hmf_in_if import hmf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SC_W-1:0]     subcarrier;
  sample_t             y_re;
  sample_t             y_im;
  sample_t             h0_re;
  sample_t             h0_im;
  sample_t             h1_re;
  sample_t             h1_im;
  sample_t             h2_re;
  sample_t             h2_im;
  sample_t             h3_re;
  sample_t             h3_im;
  logic                last_antenna;

  modport source (
    output valid, subcarrier, y_re, y_im, h0_re, h0_im, h1_re, h1_im,
           h2_re, h2_im, h3_re, h3_im, last_antenna,
    input  ready
  );
  modport sink (
    input  valid, subcarrier, y_re, y_im, h0_re, h0_im, h1_re, h1_im,
           h2_re, h2_im, h3_re, h3_im, last_antenna,
    output ready
  );
endinterface

// ===== rtl/hmf_out_if.sv =====
// Result channel: four saturated complex sums for one subcarrier.
// Depends on hmf_pkg.
interface hmf_out_if import hmf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SC_W-1:0] out_subcarrier;
  acc_t            z0_re;
  acc_t            z0_im;
  acc_t            z1_re;
  acc_t            z1_im;
  acc_t            z2_re;
  acc_t            z2_im;
  acc_t            z3_re;
  acc_t            z3_im;

  modport source (
    output valid, out_subcarrier, z0_re, z0_im, z1_re, z1_im,
           z2_re, z2_im, z3_re, z3_im,
    input  ready
  );
  modport sink (
    input  valid, out_subcarrier, z0_re, z0_im, z1_re, z1_im,
           z2_re, z2_im, z3_re, z3_im,
    output ready
  );
endinterface

// ===== rtl/hermitian_matched_filter_mac_top.sv =====
// Hermitian matched filter z = H^H y for four streams, 64 subcarriers.
// Depends on hmf_pkg, hmf_in_if and hmf_out_if.
//
// The block takes one antenna transaction per clock while the pipeline is not
// held and adds conj(h_k)*y into the four complex accumulators of that
// subcarrier; a transaction marked last_antenna produces the four saturated
// sums and clears the entry. The accumulators live in one 64 x 320-bit memory
// with registered read, read at accept and written back from stage 3, so the
// unstalled rate is one transaction per cycle, set by the one read and one
// write the memory takes each cycle. Back-to-back hits on the same subcarrier
// are forwarded from the write-back stage. A result passes through stages 1,
// 2 and 3 into the output register. Reset clears a valid bit per entry, so
// the block accepts transactions directly after reset. The whole pipeline
// holds while a result waits and the output side is not ready.
module hermitian_matched_filter_mac_top import hmf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hmf_in_if.sink    in_ch,
  hmf_out_if.source out_ch
);

  // Accumulator memory and per-entry valid bits
  acc_row_t         mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  acc_row_t         rd_r;
  logic             vld_rd_r;

  // Pipeline control
  logic adv;
  logic wr_en;
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_last_r, s2_last_r, s3_last_r;
  logic [SC_W-1:0] s1_sc_r, s2_sc_r, s3_sc_r;

  // Stage 1: operands
  sample_t s1_y_re_r, s1_y_im_r;
  sample_t s1_hre_r [NUM_STREAMS];
  sample_t s1_him_r [NUM_STREAMS];
  logic     s1_fwd_r;
  acc_row_t s1_acc_r;
  acc_row_t s1_op;

  // Stage 2: products
  prod_t    s2_p_rr_r [NUM_STREAMS];
  prod_t    s2_p_ii_r [NUM_STREAMS];
  prod_t    s2_p_ir_r [NUM_STREAMS];
  prod_t    s2_p_ri_r [NUM_STREAMS];
  acc_row_t s2_acc_r;
  term_row_t s2_term;

  // Stage 3: terms, accumulate, write back
  term_row_t s3_term_r;
  acc_row_t  s3_acc_r;
  acc_row_t  s3_sum;
  acc_row_t  wb_row;

  // Output register
  logic            out_valid_r;
  logic [SC_W-1:0] out_sc_r;
  acc_row_t        out_z_r;

  // Whole pipeline advances unless a result is stuck in the output register
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign wr_en        = adv && s3_v_r;

  // Memory read at accept, write back from stage 3
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r     <= mem[in_ch.subcarrier];
      vld_rd_r <= vld_r[in_ch.subcarrier];
    end
    if (wr_en) begin
      mem[s3_sc_r] <= wb_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s3_sc_r] <= 1'b1;
    end
  end

  // Control shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_ch.valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r && s3_last_r;
    end
  end

  // Stage 1 capture, with bypass of the write happening at the same edge
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sc_r     <= in_ch.subcarrier;
      s1_last_r   <= in_ch.last_antenna;
      s1_y_re_r   <= in_ch.y_re;
      s1_y_im_r   <= in_ch.y_im;
      s1_hre_r[0] <= in_ch.h0_re;
      s1_him_r[0] <= in_ch.h0_im;
      s1_hre_r[1] <= in_ch.h1_re;
      s1_him_r[1] <= in_ch.h1_im;
      s1_hre_r[2] <= in_ch.h2_re;
      s1_him_r[2] <= in_ch.h2_im;
      s1_hre_r[3] <= in_ch.h3_re;
      s1_him_r[3] <= in_ch.h3_im;
      s1_fwd_r    <= wr_en && (s3_sc_r == in_ch.subcarrier);
      s1_acc_r    <= wb_row;
    end
  end

  // Accumulator operand seen by stage 1
  always_comb begin
    if (s1_fwd_r) begin
      s1_op = s1_acc_r;
    end else if (vld_rd_r) begin
      s1_op = rd_r;
    end else begin
      s1_op = '0;
    end
  end

  // Stage 2: sixteen 16x16 products; operand keeps tracking write-backs
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sc_r   <= s1_sc_r;
      s2_last_r <= s1_last_r;
      for (int k = 0; k < NUM_STREAMS; k++) begin
        s2_p_rr_r[k] <= prod_t'(s1_y_re_r) * prod_t'(s1_hre_r[k]);
        s2_p_ii_r[k] <= prod_t'(s1_y_im_r) * prod_t'(s1_him_r[k]);
        s2_p_ir_r[k] <= prod_t'(s1_y_im_r) * prod_t'(s1_hre_r[k]);
        s2_p_ri_r[k] <= prod_t'(s1_y_re_r) * prod_t'(s1_him_r[k]);
      end
      s2_acc_r <= (wr_en && (s3_sc_r == s1_sc_r)) ? wb_row : s1_op;
    end
  end

  // conj(h)*y terms
  always_comb begin
    for (int k = 0; k < NUM_STREAMS; k++) begin
      s2_term[2*k]   = TERM_W'(s2_p_rr_r[k]) + TERM_W'(s2_p_ii_r[k]);
      s2_term[2*k+1] = TERM_W'(s2_p_ir_r[k]) - TERM_W'(s2_p_ri_r[k]);
    end
  end

  // Stage 3 capture
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sc_r   <= s2_sc_r;
      s3_last_r <= s2_last_r;
      s3_term_r <= s2_term;
      s3_acc_r  <= (wr_en && (s3_sc_r == s2_sc_r)) ? wb_row : s2_acc_r;
    end
  end

  // Saturating accumulate; a last antenna clears the entry
  always_comb begin
    for (int r = 0; r < ACC_PER_ROW; r++) begin
      s3_sum[r] = sat_add(s3_acc_r[r], s3_term_r[r]);
    end
    wb_row = s3_last_r ? '0 : s3_sum;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_sc_r <= s3_sc_r;
      out_z_r  <= s3_sum;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_subcarrier = out_sc_r;
  assign out_ch.z0_re          = out_z_r[0];
  assign out_ch.z0_im          = out_z_r[1];
  assign out_ch.z1_re          = out_z_r[2];
  assign out_ch.z1_im          = out_z_r[3];
  assign out_ch.z2_re          = out_z_r[4];
  assign out_ch.z2_im          = out_z_r[5];
  assign out_ch.z3_re          = out_z_r[6];
  assign out_ch.z3_im          = out_z_r[7];

  // A last-antenna transaction leaving stage 3 always reaches the output
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && s3_last_r |=> out_valid_r && (out_sc_r == $past(s3_sc_r)))
    else $error("last antenna did not produce a result");

  // Non-last transactions never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !(s3_v_r && s3_last_r) |=> !out_valid_r)
    else $error("result without a last antenna");

  // A written entry is marked valid afterwards
  a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(s3_sc_r)])
    else $error("valid bit not set after write-back");

  // A cleared entry reads back as zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && s3_last_r |=> (mem[$past(s3_sc_r)] == '0))
    else $error("entry not cleared after last antenna");

endmodule
